FILE: hw/rtl/wall_slip_value_fraction_core_defines.svh
// Assertion macros for the wall slip value fraction core
`ifndef WALL_SLIP_VALUE_FRACTION_CORE_DEFINES_SVH
`define WALL_SLIP_VALUE_FRACTION_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define WSVF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked also during reset
`define WSVF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/wsvf_pkg.sv
// ----------------------------------------------------------------------------
// wsvf_pkg
// Shared types and constants of the wall slip value fraction core.
// ----------------------------------------------------------------------------
package wsvf_pkg;

  localparam int unsigned NumRegs  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLIP_THRESHOLD    = 2'd0,
    REG_SATURATION_STRESS = 2'd1,
    REG_ACTIVATION_MAX    = 2'd2,
    REG_CELL_SIZE         = 2'd3
  } reg_idx_e;

  localparam logic [30:0] ThresholdReset  = 31'd16777;
  localparam logic [30:0] SaturationReset = 31'd18455;
  localparam logic [16:0] ActMaxReset     = 17'd65536;
  localparam logic [31:0] CellSizeReset   = 32'd429497;
  localparam logic [16:0] OneQ16          = 17'd65536;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [30:0] slip_threshold;
    logic [30:0] saturation_stress;
    logic [16:0] activation_max;
    logic [31:0] cell_size;
  } cfg_t;

endpackage

FILE: hw/rtl/wsvf_div_stage.sv
// ----------------------------------------------------------------------------
// wsvf_div_stage
// One pipelined restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsvf_div_stage import wsvf_pkg::*; #(
  parameter int unsigned RemW = 50,
  parameter int unsigned DenW = 49
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RemW-1:0] rem_i,
  input  logic [DenW-1:0] den_i,
  input  logic            num_bit_i,
  output logic [RemW-1:0] rem_o,
  output logic            q_bit_o
);

  logic [RemW:0]   shifted;
  logic [RemW:0]   diff;
  logic [RemW-1:0] rem_d, rem_q;
  logic            q_d, q_q;

  // shift in next numerator bit, try subtract
  always_comb begin
    shifted = {rem_i, num_bit_i};
    diff    = shifted - {{(RemW+1-DenW){1'b0}}, den_i};
    if (shifted >= {{(RemW+1-DenW){1'b0}}, den_i}) begin
      rem_d = diff[RemW-1:0];
      q_d   = 1'b1;
    end else begin
      rem_d = shifted[RemW-1:0];
      q_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign rem_o   = rem_q;
  assign q_bit_o = q_q;

endmodule

FILE: hw/rtl/wall_slip_value_fraction_core.sv
// Pipeline stages from input transaction to result: 3 magnitude, 32 square
// root, 4 activation, 17 divide, 3 select/denominator, 17 divide, 1 output.
// Throughput: one transaction per cycle unless the output stalls; each root and
// quotient bit has its own pipeline stage, so a stall freezes the whole pipeline.
// Reset: asynchronous active low; clears valid bits and loads register resets.
// ----------------------------------------------------------------------------
// wall_slip_value_fraction_core
// Stress magnitude, slip activation and boundary value fraction per face.
// ----------------------------------------------------------------------------
module wall_slip_value_fraction_core import wsvf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  stress_x_i,
  input  logic signed [31:0]  stress_y_i,
  input  logic signed [31:0]  stress_z_i,
  input  logic [31:0]         slip_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [16:0]         slip_activation_o,
  output logic [16:0]         value_fraction_o
);

  localparam int unsigned SqSteps = 32;
  localparam int unsigned QBits   = 17;
  // stages: 0 abs, 1 squares, 2 sum, 3..34 root, 35 diffs, 36 squares,
  // 37 sum/norm, 38 product, 39..55 div, 56 select, 57 product, 58 den,
  // then 17 divide stages, then output register
  localparam int unsigned NStg = 3 + SqSteps + 4 + QBits + 3 + QBits + 1;

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slip_threshold    <= ThresholdReset;
      cfg_q.saturation_stress <= SaturationReset;
      cfg_q.activation_max    <= ActMaxReset;
      cfg_q.cell_size         <= CellSizeReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SLIP_THRESHOLD:    cfg_q.slip_threshold    <= cfg_data_i[30:0];
        REG_SATURATION_STRESS: cfg_q.saturation_stress <= cfg_data_i[30:0];
        REG_ACTIVATION_MAX:    cfg_q.activation_max    <= cfg_data_i[16:0];
        REG_CELL_SIZE:         cfg_q.cell_size         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global pipeline enable: all stages move together
  logic en;
  logic [NStg-1:0] vld_q;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // slip length travels alongside
  logic [31:0] len_q [QBits+40];
  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q[0] <= slip_length_i;
      for (int i = 1; i < QBits + 40; i++) len_q[i] <= len_q[i-1];
    end
  end

  // ---- magnitude ----
  logic [31:0] ax_q, ay_q, az_q;
  logic [63:0] sx_q, sy_q, sz_q, ssum_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= stress_x_i[31] ? 32'(-stress_x_i) : stress_x_i;
      ay_q   <= stress_y_i[31] ? 32'(-stress_y_i) : stress_y_i;
      az_q   <= stress_z_i[31] ? 32'(-stress_z_i) : stress_z_i;
      sx_q   <= 64'(ax_q) * 64'(ax_q);
      sy_q   <= 64'(ay_q) * 64'(ay_q);
      sz_q   <= 64'(az_q) * 64'(az_q);
      ssum_q <= sx_q + sy_q + sz_q;
    end
  end

  // digit-by-digit root, one result bit per stage
  logic [63:0] rx_q [SqSteps+1];
  logic [31:0] rr_q [SqSteps+1];
  always_comb begin
    rx_q[0] = ssum_q;
    rr_q[0] = '0;
  end
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [33:0] rem_hi;
    logic [33:0] trial;
    logic [63:0] rx_n;
    logic [31:0] rr_n;
    localparam int unsigned Sh = 2 * (SqSteps - 1 - k);
    always_comb begin
      rem_hi = 34'(rx_q[k] >> Sh);
      trial  = {rr_q[k], 2'b01};
      rx_n   = rx_q[k];
      rr_n   = {rr_q[k][30:0], 1'b0};
      if (rem_hi >= trial) begin
        rx_n = rx_q[k] - (64'(trial) << Sh);
        rr_n = {rr_q[k][30:0], 1'b1};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k+1] <= rx_n;
        rr_q[k+1] <= rr_n;
      end
    end
  end

  logic [31:0] s_mag;
  assign s_mag = rr_q[SqSteps];

  // ---- activation ----
  logic [16:0] fmax;
  assign fmax = (cfg_q.activation_max > OneQ16) ? OneQ16 : cfg_q.activation_max;

  typedef enum logic [1:0] {ACT_ZERO, ACT_MAX, ACT_DIV} act_e;
  act_e        am_d;
  act_e        am_q [1:QBits+4];
  logic [31:0] dg_q, dx_q;
  logic [63:0] a_q, e_q;
  logic [45:0] an_q, bn_q;

  always_comb begin
    if (s_mag < {1'b0, cfg_q.slip_threshold}) am_d = ACT_ZERO;
    else if (s_mag >= {1'b0, cfg_q.saturation_stress}) am_d = ACT_MAX;
    else am_d = ACT_DIV;
  end

  // normalize so the denominator is below 2^46
  logic [64:0] b_full;
  logic [5:0]  nsh;
  assign b_full = 65'(a_q) + 65'(e_q);
  always_comb begin
    nsh = '0;
    for (int i = 46; i <= 64; i++) if (b_full[i]) nsh = 6'(i - 45);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q  <= s_mag - {1'b0, cfg_q.slip_threshold};
      dx_q  <= {1'b0, cfg_q.saturation_stress} - s_mag;
      a_q   <= 64'(dg_q) * 64'(dg_q);
      e_q   <= 64'(dx_q) * 64'(dx_q);
      an_q  <= 46'(a_q >> nsh);
      bn_q  <= 46'(b_full >> nsh);
      am_q[1] <= am_d;
      for (int i = 2; i <= QBits + 4; i++) am_q[i] <= am_q[i-1];
    end
  end

  // bn stays with the divider; the numerator product is the first divider input
  logic [45:0] bd_q [QBits+1];
  logic [62:0] nd_q [QBits];
  logic [16:0] fq_q [1:QBits];
  logic [46:0] fr_q [QBits+1];
  always_comb begin
    fr_q[0] = '0;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      bd_q[0] <= bn_q;
      bd_q[1] <= bd_q[0];
      nd_q[0] <= 63'(an_q) * 63'(fmax);
      for (int i = 2; i <= QBits; i++) bd_q[i] <= bd_q[i-1];
      for (int i = 1; i < QBits; i++) nd_q[i] <= nd_q[i-1];
    end
  end

  // quotient fits in 17 bits; top numerator bits fold into the first remainder
  for (genvar k = 0; k < QBits; k++) begin : g_fdiv
    logic [46:0] rem_in;
    assign rem_in = (k == 0) ? 47'(nd_q[0] >> QBits) : fr_q[k];
    wsvf_div_stage #(.RemW(47), .DenW(46)) u_step (
      .clk_i    (clk_i),
      .en_i     (en),
      .rem_i    (rem_in),
      .den_i    (bd_q[k]),
      .num_bit_i(nd_q[k][QBits-1-k]),
      .rem_o    (fr_q[k+1]),
      .q_bit_o  (fq_q[k+1][0])
    );
    if (k > 0) begin : g_acc
      always_ff @(posedge clk_i) if (en) fq_q[k+1][16:1] <= fq_q[k][15:0];
    end else begin : g_acc0
      assign fq_q[1][16:1] = '0;
    end
  end

  // select activation, then 2*L*f and the fraction denominator
  logic [16:0] f_q;
  logic [47:0] lf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      case (am_q[QBits+4])
        ACT_ZERO: f_q <= '0;
        ACT_MAX:  f_q <= fmax;
        default:  f_q <= (bd_q[QBits] == '0) ? fmax : fq_q[QBits];
      endcase
      lf_q <= 48'(len_q[QBits+39]) * 48'(f_q);
    end
  end

  logic [16:0] f_dly [QBits+2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_dly[0] <= f_q;
      for (int i = 1; i < QBits + 2; i++) f_dly[i] <= f_dly[i-1];
    end
  end

  // fraction divider: (d<<32)/den, quotient below 2^17
  logic [49:0] vd_q [QBits+1];
  logic [63:0] vn_q [QBits];
  logic [16:0] vq_q [1:QBits];
  logic [50:0] vr_q [QBits+1];
  always_comb begin
    vr_q[0] = '0;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vd_q[0] <= 50'({cfg_q.cell_size, 16'd0}) + 50'({lf_q, 1'b0});
      vn_q[0] <= {cfg_q.cell_size, 32'd0};
      for (int i = 1; i <= QBits; i++) vd_q[i] <= vd_q[i-1];
      for (int i = 1; i < QBits; i++) vn_q[i] <= vn_q[i-1];
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_vdiv
    logic [50:0] rem_in;
    assign rem_in = (k == 0) ? 51'(vn_q[0] >> QBits) : vr_q[k];
    wsvf_div_stage #(.RemW(51), .DenW(50)) u_step (
      .clk_i    (clk_i),
      .en_i     (en),
      .rem_i    (rem_in),
      .den_i    (vd_q[k]),
      .num_bit_i(vn_q[k][QBits-1-k]),
      .rem_o    (vr_q[k+1]),
      .q_bit_o  (vq_q[k+1][0])
    );
    if (k > 0) begin : g_acc
      always_ff @(posedge clk_i) if (en) vq_q[k+1][16:1] <= vq_q[k][15:0];
    end else begin : g_acc0
      assign vq_q[1][16:1] = '0;
    end
  end

  // output register
  logic [16:0] act_q, vf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_q <= f_dly[QBits+1];
      vf_q  <= (vd_q[QBits] == '0) ? OneQ16 : vq_q[QBits];
    end
  end

  assign slip_activation_o = act_q;
  assign value_fraction_o  = vf_q;

endmodule

FILE: hw/rtl/wsvf_checker.sv
// ----------------------------------------------------------------------------
// wsvf_checker
// Port-level checks of the wall slip value fraction core.
// ----------------------------------------------------------------------------
`include "wall_slip_value_fraction_core_defines.svh"

module wsvf_checker import wsvf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [16:0] slip_activation_o,
  input logic [16:0] value_fraction_o
);

  `WSVF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(value_fraction_o), "stalled result changed")
  `WSVF_ASSERT(a_stall_src, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output stall")
  `WSVF_ASSERT(a_act_rng, clk_i, rst_ni, out_valid_o |-> slip_activation_o <= OneQ16, "activation out of range")
  `WSVF_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !out_valid_o, "valid during reset")

endmodule

bind wall_slip_value_fraction_core wsvf_checker u_wsvf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .slip_activation_o(slip_activation_o),
  .value_fraction_o (value_fraction_o)
);
